/* rtl/core/assert_macros.svh */
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on an explicit clock and active-low reset
`define ASD_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// same, on the house clock and reset names
`define ASD_ASSERT_DEF(lbl, prop, msg) \
  `ASD_ASSERT(lbl, clk_i, rst_ni, prop, msg)

`endif

/* rtl/core/asd_pkg.sv */
// ----------------------------------------------------------------------------
// asd_pkg
// Shared widths, constants, register codes and control types of the
// accelerometer step detector.
// ----------------------------------------------------------------------------
`default_nettype none

package asd_pkg;

  // field widths
  localparam int AXIS_W   = 16;
  localparam int SAX_W    = 12;  // axis after arithmetic shift right by 4
  localparam int AXIS_SHR = 4;
  localparam int SQ_W     = 24;  // sum of three squares
  localparam int MAG_W    = 12;
  localparam int SUM3_W   = 14;  // sum of three magnitudes
  localparam int PC_W     = 3;
  localparam int WC_W     = 4;
  localparam int THR_W    = 12;
  localparam int CW_W     = 4;
  localparam int MP_W     = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DW   = 12;
  localparam int CNT_W    = 4;

  // divide by three as multiply by reciprocal, exact for sums below 2^15
  localparam int RECIP_W     = 15;
  localparam int RECIP_SHIFT = 16;
  localparam int PROD_W      = SUM3_W + RECIP_W;
  localparam logic [RECIP_W-1:0] RECIP3 = 15'd21846;

  // square root iteration
  localparam int ROOT_STEPS = SQ_W / 2;
  localparam logic [SQ_W-1:0] ROOT_TOP_BIT = SQ_W'(1) << (SQ_W - 2);
  localparam logic [CNT_W-1:0] ROOT_LAST = CNT_W'(ROOT_STEPS - 1);
  localparam logic [CNT_W-1:0] SQ_LAST   = CNT_W'(2);

  // largest magnitude the axis range can give
  localparam logic [MAG_W-1:0] MAG_MAX = 12'd3547;

  // register reset values
  localparam logic [THR_W-1:0] THR_RST = 12'd45;
  localparam logic [CW_W-1:0]  CW_RST  = 4'd5;
  localparam logic [MP_W-1:0]  MP_RST  = 2'd2;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PEAK_THRESHOLD = 2'd0,
    CFG_CONFIRM_WINDOW = 2'd1,
    CFG_MAX_PEAKS      = 2'd2
  } cfg_idx_e;

  // controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_ROOT,
    ST_AVERAGE,
    ST_FINISH
  } ctrl_state_e;

  // controller to datapath commands
  typedef struct packed {
    logic       load;        // capture scaled axes, clear accumulator
    logic       sq_en;       // accumulate one square
    logic [1:0] sq_sel;      // axis to square
    logic       root_en;     // one square root iteration
    logic       root_first;  // first iteration takes the accumulator
    logic       avg_en;      // three-sample average
    logic       finish;      // peak test, history and output load
  } asd_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic out_free;          // output register can take a word
  } asd_status_t;

endpackage

`default_nettype wire

/* rtl/core/asd_if.sv */
// ----------------------------------------------------------------------------
// asd_if
// Valid/ready channel interfaces of the step detector: sample input, result
// output and configuration write.
// ----------------------------------------------------------------------------
`default_nettype none

interface asd_in_if;
  import asd_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [AXIS_W-1:0] accel_x;
  logic signed [AXIS_W-1:0] accel_y;
  logic signed [AXIS_W-1:0] accel_z;

  modport source (output valid, accel_x, accel_y, accel_z, input ready);
  modport sink   (input valid, accel_x, accel_y, accel_z, output ready);
endinterface

interface asd_out_if;
  import asd_pkg::*;
  logic             valid;
  logic             ready;
  logic             step_detected;
  logic [MAG_W-1:0] smoothed_magnitude;

  modport source (output valid, step_detected, smoothed_magnitude, input ready);
  modport sink   (input valid, step_detected, smoothed_magnitude, output ready);
endinterface

interface asd_cfg_if;
  import asd_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [CFG_DW-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/asd_ctrl.sv */
// ----------------------------------------------------------------------------
// asd_ctrl
// Sequencer of the step detector: accept, three squares, square root
// iterations, average, then history update and output load.
// ----------------------------------------------------------------------------
`default_nettype none

module asd_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  output asd_pkg::asd_cmd_t    cmd_o,
  input  asd_pkg::asd_status_t status_i
);
  import asd_pkg::*;

  ctrl_state_e      state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // state and step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // next state and commands
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = ST_SQUARE;
        end
      end
      ST_SQUARE: begin
        cmd_o.sq_en  = 1'b1;
        cmd_o.sq_sel = cnt_q[1:0];
        if (cnt_q == SQ_LAST) begin
          cnt_d   = '0;
          state_d = ST_ROOT;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_ROOT: begin
        cmd_o.root_en    = 1'b1;
        cmd_o.root_first = (cnt_q == '0);
        if (cnt_q == ROOT_LAST) begin
          cnt_d   = '0;
          state_d = ST_AVERAGE;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ST_AVERAGE: begin
        cmd_o.avg_en = 1'b1;
        state_d      = ST_FINISH;
      end
      ST_FINISH: begin
        // wait here while the previous word is still unclaimed
        if (status_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/core/asd_datapath.sv */
// ----------------------------------------------------------------------------
// asd_datapath
// Arithmetic and state of the step detector: shared squarer, iterative
// square root, divide-by-three average, peak window, counters, config
// registers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module asd_datapath (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire signed [asd_pkg::AXIS_W-1:0] accel_x_i,
  input  wire signed [asd_pkg::AXIS_W-1:0] accel_y_i,
  input  wire signed [asd_pkg::AXIS_W-1:0] accel_z_i,
  input  asd_pkg::asd_cmd_t             cmd_i,
  output asd_pkg::asd_status_t          status_o,
  asd_cfg_if.sink                      cfg_i,
  asd_out_if.source                    out_o
);
  import asd_pkg::*;

  // config registers
  logic [THR_W-1:0] thr_q;
  logic [CW_W-1:0]  cw_q;
  logic [MP_W-1:0]  mp_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RST;
      cw_q  <= CW_RST;
      mp_q  <= MP_RST;
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_PEAK_THRESHOLD: thr_q <= cfg_i.data[THR_W-1:0];
        CFG_CONFIRM_WINDOW: cw_q  <= cfg_i.data[CW_W-1:0];
        CFG_MAX_PEAKS:      mp_q  <= cfg_i.data[MP_W-1:0];
        default: ;
      endcase
    end
  end

  // scaled axes, squarer and accumulator
  logic signed [SAX_W-1:0] ax_q [3];
  logic signed [SAX_W-1:0] sq_op;
  logic signed [SQ_W-1:0]  sq;
  logic [SQ_W-1:0]         acc_q;

  always_comb begin
    case (cmd_i.sq_sel)
      2'd0:    sq_op = ax_q[0];
      2'd1:    sq_op = ax_q[1];
      default: sq_op = ax_q[2];
    endcase
    sq = sq_op * sq_op;
  end

  // square root, one result bit per step
  logic [SQ_W-1:0] rem_q, root_q, bit_q;
  logic [SQ_W-1:0] rem_cur, root_cur, bit_cur;
  logic [SQ_W:0]   trial;
  logic            take;

  always_comb begin
    rem_cur  = cmd_i.root_first ? acc_q : rem_q;
    root_cur = cmd_i.root_first ? '0 : root_q;
    bit_cur  = cmd_i.root_first ? ROOT_TOP_BIT : bit_q;
    trial    = {1'b0, root_cur} + {1'b0, bit_cur};
    take     = ({1'b0, rem_cur} >= trial);
  end

  // three-sample average
  logic [MAG_W-1:0]  mag_hist_q [2];
  logic [MAG_W-1:0]  mag;
  logic [SUM3_W-1:0] sum3;
  logic [PROD_W-1:0] prod;
  logic [MAG_W-1:0]  smooth_q;

  assign mag  = root_q[MAG_W-1:0];
  assign sum3 = SUM3_W'(mag_hist_q[0]) + SUM3_W'(mag_hist_q[1]) + SUM3_W'(mag);
  assign prod = PROD_W'(sum3) * PROD_W'(RECIP3);

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q[0] <= accel_x_i[AXIS_W-1:AXIS_SHR];
      ax_q[1] <= accel_y_i[AXIS_W-1:AXIS_SHR];
      ax_q[2] <= accel_z_i[AXIS_W-1:AXIS_SHR];
      acc_q   <= '0;
    end else if (cmd_i.sq_en) begin
      acc_q <= acc_q + SQ_W'(unsigned'(sq));
    end
    if (cmd_i.root_en) begin
      rem_q  <= take ? SQ_W'({1'b0, rem_cur} - trial) : rem_cur;
      root_q <= take ? ((root_cur >> 1) + bit_cur) : (root_cur >> 1);
      bit_q  <= bit_cur >> 2;
    end
    if (cmd_i.avg_en) begin
      smooth_q <= prod[RECIP_SHIFT +: MAG_W];
    end
  end

  // peak window test
  logic [MAG_W-1:0] sm_hist_q [4];
  logic             shape, peak;
  logic [MAG_W-1:0] rise_l, rise_r;

  always_comb begin
    shape  = (sm_hist_q[0] <= sm_hist_q[1]) && (sm_hist_q[1] <= sm_hist_q[2]) &&
             (sm_hist_q[2] >= sm_hist_q[3]) && (sm_hist_q[3] >= smooth_q);
    rise_l = sm_hist_q[2] - sm_hist_q[0];
    rise_r = sm_hist_q[2] - smooth_q;
    peak   = shape && ((rise_l >= thr_q) || (rise_r >= thr_q));
  end

  // peak and window counters
  logic [PC_W-1:0] pc_q, pc_inc, pc_d;
  logic [WC_W-1:0] wc_q, wc_inc, wc_d;
  logic            step_d;

  always_comb begin
    pc_inc = peak ? pc_q + 1'b1 : pc_q;
    wc_inc = wc_q + 1'b1;
    pc_d   = pc_inc;
    wc_d   = wc_q;
    step_d = 1'b0;
    if (pc_inc != '0) begin
      wc_d = wc_inc;
      if (pc_inc > PC_W'(mp_q)) begin
        pc_d = '0;
        wc_d = '0;
      end else if (wc_inc >= cw_q) begin
        pc_d   = '0;
        wc_d   = '0;
        step_d = 1'b1;
      end
    end
  end

  // history and counter state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mag_hist_q <= '{default: '0};
      sm_hist_q  <= '{default: '0};
      pc_q       <= '0;
      wc_q       <= '0;
    end else if (cmd_i.finish) begin
      mag_hist_q[0] <= mag_hist_q[1];
      mag_hist_q[1] <= mag;
      sm_hist_q[0]  <= sm_hist_q[1];
      sm_hist_q[1]  <= sm_hist_q[2];
      sm_hist_q[2]  <= sm_hist_q[3];
      sm_hist_q[3]  <= smooth_q;
      pc_q          <= pc_d;
      wc_q          <= wc_d;
    end
  end

  // output register
  logic             out_valid_q;
  logic             out_step_q;
  logic [MAG_W-1:0] out_mag_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      out_step_q <= step_d;
      out_mag_q  <= smooth_q;
    end
  end

  assign status_o.out_free         = !out_valid_q || out_o.ready;
  assign out_o.valid              = out_valid_q;
  assign out_o.step_detected      = out_step_q;
  assign out_o.smoothed_magnitude = out_mag_q;

endmodule

`default_nettype wire

/* rtl/core/accel_step_detector.sv */
// ----------------------------------------------------------------------------
// accel_step_detector
// Pedometer peak detection on three-axis accelerometer samples.
// ----------------------------------------------------------------------------
// Each accepted sample gives exactly one result word (step flag and smoothed
// magnitude). One sample is processed at a time: acceptance, three squares on
// the single shared 12x12 squarer, twelve iterations of the bit-serial square
// root, averaging, then peak test and history update. The result sits in an
// output register, so the next sample is taken while it waits; only a second
// result stalls in the finish state until the first is taken. Configuration
// writes are always ready and apply immediately; they should be issued only
// while no sample is in flight.
`default_nettype none

module accel_step_detector (
  input  wire       clk_i,
  input  wire       rst_ni,
  asd_in_if.sink    in_i,
  asd_out_if.source out_o,
  asd_cfg_if.sink   cfg_i
);
  import asd_pkg::*;

  asd_cmd_t    cmd;
  asd_status_t status;
  logic        in_ready;

  assign in_i.ready = in_ready;

  // sequencer
  asd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  // arithmetic and state
  asd_datapath u_datapath (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accel_x_i (in_i.accel_x),
    .accel_y_i (in_i.accel_y),
    .accel_z_i (in_i.accel_z),
    .cmd_i     (cmd),
    .status_o  (status),
    .cfg_i     (cfg_i),
    .out_o     (out_o)
  );

endmodule

`default_nettype wire

/* rtl/core/asd_checker.sv */
// ----------------------------------------------------------------------------
// asd_checker
// Port-level checks of the step detector, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module asd_checker (
  input wire                        clk_i,
  input wire                        rst_ni,
  input wire                        in_valid_i,
  input wire                        in_ready_i,
  input wire                        out_valid_i,
  input wire                        out_ready_i,
  input wire                        step_detected_i,
  input wire [asd_pkg::MAG_W-1:0]   smoothed_magnitude_i
);
  import asd_pkg::*;

  // a stalled word holds
  `ASD_ASSERT_DEF(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(step_detected_i) && $stable(smoothed_magnitude_i), "output word changed while stalled")

  // magnitude never exceeds what the axis range allows
  `ASD_ASSERT_DEF(a_mag_range, out_valid_i |-> smoothed_magnitude_i <= MAG_MAX, "smoothed magnitude out of range")

  // one sample at a time
  `ASD_ASSERT_DEF(a_one_item, in_valid_i && in_ready_i |=> !in_ready_i, "sample accepted while busy")

  // a fresh result appears only when the block is back to idle
  `ASD_ASSERT_DEF(a_result_idle, $rose(out_valid_i) |-> in_ready_i, "result raised while still busy")

endmodule

bind accel_step_detector asd_checker u_asd_checker (
  .clk_i                (clk_i),
  .rst_ni               (rst_ni),
  .in_valid_i           (in_i.valid),
  .in_ready_i           (in_i.ready),
  .out_valid_i          (out_o.valid),
  .out_ready_i          (out_o.ready),
  .step_detected_i      (out_o.step_detected),
  .smoothed_magnitude_i (out_o.smoothed_magnitude)
);

`default_nettype wire

/* bench/accel_step_detector_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// accel_step_detector_tb
// Self-checking bench for the step detector. A plan of sample words,
// register writes and drain points is built up front and played out by a
// clocked driver with random gaps; a clocked monitor predicts each result
// word from its own copy of the detector state and checks it field by field.
// ----------------------------------------------------------------------------

module accel_step_detector_tb;
  import asd_pkg::*;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 4;
  localparam int RANDOM_ITEMS   = 700;
  localparam int SETTLE_CYCLES  = 4;
  localparam int TAIL_CYCLES    = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int CALM_FROM      = 300;
  localparam int CALM_TO        = 450;
  localparam int AVG_TAPS       = 3;
  localparam int MAX_GAP        = 30;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 2'd3;

  typedef enum logic [1:0] {
    JOB_SAMPLE,
    JOB_WRITE,
    JOB_DRAIN
  } job_kind_e;

  typedef struct {
    job_kind_e                kind;
    logic signed [AXIS_W-1:0] ax;
    logic signed [AXIS_W-1:0] ay;
    logic signed [AXIS_W-1:0] az;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DW-1:0]        data;
  } plan_entry_t;

  typedef struct packed {
    logic             step;
    logic [MAG_W-1:0] smooth;
  } step_word_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  asd_in_if  smp_if ();
  asd_out_if res_if ();
  asd_cfg_if cfg_if ();

  accel_step_detector uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (smp_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  // predictor copy of the detector registers and history
  logic [THR_W-1:0] thr_reg  = THR_RST;
  logic [CW_W-1:0]  cwin_reg = CW_RST;
  logic [MP_W-1:0]  maxp_reg = MP_RST;
  logic [MAG_W-1:0] mag_hist [2]    = '{default: '0};
  logic [MAG_W-1:0] smooth_hist [4] = '{default: '0};
  logic [PC_W-1:0]  peak_cnt = '0;
  logic [WC_W-1:0]  win_cnt  = '0;

  plan_entry_t sample_plan [$];
  step_word_t  step_words_due [$];

  int   mismatches   = 0;
  int   smp_count    = 0;
  int   cfg_count    = 0;
  int   word_count   = 0;
  int   step_count   = 0;
  int   planned      = 0;
  int   send_gap     = 0;
  int   recv_stall   = 0;
  int   idle_run     = 0;
  int   quiet_cycles = 0;
  logic calm         = 1'b0;
  logic smp_fire     = 1'b0;
  logic cfg_fire     = 1'b0;

  // clock
  always begin
    #(HALF_PERIOD) clk_i = 1'b1;
    #(HALF_PERIOD) clk_i = 1'b0;
  end

  // exact floor square root of a sum of squares
  function automatic logic [MAG_W-1:0] isqrt24(input logic [SQ_W-1:0] n);
    logic [MAG_W-1:0] root;
    logic [MAG_W-1:0] trial;
    root = '0;
    for (int b = MAG_W - 1; b >= 0; b--) begin
      trial = root | (MAG_W'(1) << b);
      if (32'(trial) * 32'(trial) <= 32'(n)) root = trial;
    end
    return root;
  endfunction

  // register write as the detector applies it
  function automatic void apply_cfg(input logic [CFG_IDX_W-1:0] idx,
                                    input logic [CFG_DW-1:0] data);
    case (idx)
      CFG_PEAK_THRESHOLD: thr_reg  = data[THR_W-1:0];
      CFG_CONFIRM_WINDOW: cwin_reg = data[CW_W-1:0];
      CFG_MAX_PEAKS:      maxp_reg = data[MP_W-1:0];
      default: ;
    endcase
  endfunction

  // one sample in, one result word out; advances the predictor state
  function automatic step_word_t next_step_word(input logic signed [AXIS_W-1:0] ax,
                                                input logic signed [AXIS_W-1:0] ay,
                                                input logic signed [AXIS_W-1:0] az);
    int               sx, sy, sz;
    logic [MAG_W-1:0] mag, avg, s0, s1, s2, s3;
    logic             shape;
    step_word_t       w;
    sx  = int'(ax) >>> AXIS_SHR;
    sy  = int'(ay) >>> AXIS_SHR;
    sz  = int'(az) >>> AXIS_SHR;
    mag = isqrt24(SQ_W'(sx * sx + sy * sy + sz * sz));
    avg = MAG_W'((int'(mag_hist[0]) + int'(mag_hist[1]) + int'(mag)) / AVG_TAPS);
    s0  = smooth_hist[0];
    s1  = smooth_hist[1];
    s2  = smooth_hist[2];
    s3  = smooth_hist[3];
    // middle of the five-value window must be a peak tall enough
    shape = (s0 <= s1) && (s1 <= s2) && (s2 >= s3) && (s3 >= avg);
    if (shape && ((s2 - s0) >= thr_reg || (s2 - avg) >= thr_reg))
      peak_cnt = peak_cnt + 1'b1;
    mag_hist[0]    = mag_hist[1];
    mag_hist[1]    = mag;
    smooth_hist[0] = s1;
    smooth_hist[1] = s2;
    smooth_hist[2] = s3;
    smooth_hist[3] = avg;
    // window count, noise discard or step confirm
    w.step   = 1'b0;
    w.smooth = avg;
    if (peak_cnt != 0) begin
      win_cnt = win_cnt + 1'b1;
      if (peak_cnt > maxp_reg) begin
        peak_cnt = '0;
        win_cnt  = '0;
      end else if (win_cnt >= cwin_reg) begin
        peak_cnt = '0;
        win_cnt  = '0;
        w.step   = 1'b1;
      end
    end
    return w;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic plan_sample(input logic signed [AXIS_W-1:0] ax,
                             input logic signed [AXIS_W-1:0] ay,
                             input logic signed [AXIS_W-1:0] az);
    plan_entry_t e;
    e      = '{kind: JOB_SAMPLE, ax: ax, ay: ay, az: az, idx: '0, data: '0};
    sample_plan.push_back(e);
    planned++;
  endtask

  task automatic plan_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DW-1:0] data);
    plan_entry_t e;
    e = '{kind: JOB_WRITE, ax: '0, ay: '0, az: '0, idx: idx, data: data};
    sample_plan.push_back(e);
  endtask

  task automatic plan_drain();
    plan_entry_t e;
    e = '{kind: JOB_DRAIN, ax: '0, ay: '0, az: '0, idx: '0, data: '0};
    sample_plan.push_back(e);
  endtask

  // sample whose magnitude is about m, random axes, signs and dropped low bits
  task automatic plan_mag(input int m);
    int                       per, lanes, first, scaled;
    logic signed [AXIS_W-1:0] raw [3];
    if (m > 2895) begin
      lanes = 3;
      per   = (m * 37) / 64;
      if (per > 2047) per = 2047;
    end else if (m > 2047) begin
      lanes = 2;
      per   = (m * 181) / 256;
    end else begin
      lanes = 1;
      per   = m;
    end
    first = $urandom_range(2, 0);
    for (int i = 0; i < 3; i++) begin
      scaled = (((i - first + 3) % 3) < lanes) ? per : 0;
      if ($urandom_range(1, 0)) scaled = -scaled;
      raw[i] = AXIS_W'(scaled * 16 + int'($urandom_range(15, 0)));
    end
    plan_sample(raw[0], raw[1], raw[2]);
  endtask

  // walking pattern: a few bumps over a base level, sized around the threshold
  task automatic plan_gait(input int thr);
    int base, amp, lo, hi, jit, top;
    base = $urandom_range(1800, 0);
    hi   = thr * 2 + 120;
    if (hi > 1700) hi = 1700;
    lo   = thr / 2;
    if (lo > hi) lo = hi;
    amp  = $urandom_range(hi, lo);
    jit  = $urandom_range(3, 0);
    repeat ($urandom_range(4, 1)) begin
      repeat ($urandom_range(4, 1)) begin
        top = base + amp + int'($urandom_range(jit, 0));
        plan_mag(top > int'(MAG_MAX) ? int'(MAG_MAX) : top);
      end
      repeat ($urandom_range(14, 1)) plan_mag(base + int'($urandom_range(jit, 0)));
    end
  endtask

  task automatic plan_bump();
    repeat (3) plan_mag(0);
    repeat (2) plan_mag(600);
    repeat (3) plan_mag(0);
  endtask

  // stimulus plan, then wait for the end of the run
  initial begin : stimulus
    int cur_thr, phase, phase_len, start, sel;
    logic [CW_W-1:0] cw;
    logic [MP_W-1:0] mp;
    smp_if.valid   = 1'b0;
    smp_if.accel_x = '0;
    smp_if.accel_y = '0;
    smp_if.accel_z = '0;
    res_if.ready   = 1'b0;
    cfg_if.valid   = 1'b0;
    cfg_if.index   = '0;
    cfg_if.data    = '0;
    cur_thr        = int'(THR_RST);

    // directed: full scale and rounding corners of the axes
    plan_sample(-16'sd32768, -16'sd32768, -16'sd32768);
    plan_sample(16'sd32767, 16'sd32767, 16'sd32767);
    plan_sample(16'sd0, 16'sd0, 16'sd0);
    plan_sample(-16'sd32768, 16'sd32767, 16'sd0);
    plan_sample(-16'sd1, 16'sd15, -16'sd16);
    plan_sample(16'sd32767, -16'sd32768, -16'sd17);
    plan_sample(16'sd16, -16'sd32767, 16'sd32752);
    // write to an index past the register list is ignored
    plan_write(CFG_IDX_SPARE, 12'hfff);
    // zero confirm window: step on the peak's own sample
    plan_write(CFG_CONFIRM_WINDOW, 12'h000);
    plan_bump();
    // zero max peaks: first peak discards the window
    plan_write(CFG_MAX_PEAKS, 12'h000);
    plan_bump();

    // random phases, registers rewritten between them
    start = planned;
    phase = 0;
    while (planned - start < RANDOM_ITEMS) begin
      case (phase)
        0: begin
          cur_thr = 0;
          cw      = 4'd15;
          mp      = 2'd3;
        end
        1: begin
          cur_thr = 4095;
          cw      = 4'd1;
          mp      = 2'd1;
        end
        default: begin
          sel     = $urandom_range(9, 0);
          cur_thr = (sel == 0) ? 0 : (sel == 1) ? 4095 :
                    (sel == 2) ? int'($urandom_range(4095, 0)) :
                    int'($urandom_range(300, 10));
          cw      = CW_W'($urandom_range(15, 0));
          mp      = ($urandom_range(7, 0) == 0) ? 2'd0 : MP_W'($urandom_range(3, 1));
        end
      endcase
      plan_write(CFG_PEAK_THRESHOLD, CFG_DW'(cur_thr));
      plan_write(CFG_CONFIRM_WINDOW, {(CFG_DW - CW_W)'($urandom), cw});
      plan_write(CFG_MAX_PEAKS, {(CFG_DW - MP_W)'($urandom), mp});
      phase_len = planned + $urandom_range(120, 40);
      while (planned < phase_len && planned - start < RANDOM_ITEMS) begin
        sel = $urandom_range(99, 0);
        if (sel < 78) begin
          plan_gait(cur_thr);
        end else if (sel < 93) begin
          repeat ($urandom_range(5, 1))
            plan_sample(AXIS_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom));
        end else begin
          plan_drain();
        end
      end
      phase++;
    end

    // reset once, then let the plan run out
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    do @(negedge clk_i);
    while (sample_plan.size() != 0 || smp_if.valid || cfg_if.valid ||
           step_words_due.size() != 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);

    $display("covered %0d samples over %0d register writes in %0d phases", smp_count,
             cfg_count, phase);
    $display("checked %0d result words, %0d of them confirmed steps", word_count,
             step_count);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // driver: words change on the falling edge
  always @(negedge clk_i) begin : drive
    plan_entry_t job;
    logic        smp_busy, cfg_busy, give_smp, give_cfg;
    if (rst_ni) begin
      calm = (smp_count >= CALM_FROM) && (smp_count < CALM_TO);
      // random gaps on the sender and stalls on the receiver
      if (send_gap != 0) send_gap--;
      else if (!calm && $urandom_range(99, 0) == 0) send_gap = $urandom_range(MAX_GAP, 1);
      if (recv_stall != 0) recv_stall--;
      else if (!calm && $urandom_range(99, 0) == 0) recv_stall = $urandom_range(MAX_GAP, 1);
      res_if.ready <= (recv_stall == 0);

      smp_busy = smp_if.valid && !smp_fire;
      cfg_busy = cfg_if.valid && !cfg_fire;
      if (step_words_due.size() == 0 && !smp_busy) idle_run++;
      else idle_run = 0;

      if (!smp_busy && !cfg_busy) begin
        give_smp = 1'b0;
        give_cfg = 1'b0;
        if (sample_plan.size() != 0) begin
          job = sample_plan[0];
          case (job.kind)
            JOB_SAMPLE: begin
              if (send_gap == 0) begin
                give_smp = 1'b1;
                void'(sample_plan.pop_front());
              end
            end
            // writes and drain points wait for the detector to go quiet
            JOB_WRITE: begin
              if (idle_run >= SETTLE_CYCLES) begin
                give_cfg = 1'b1;
                void'(sample_plan.pop_front());
              end
            end
            default: begin
              if (idle_run >= SETTLE_CYCLES) void'(sample_plan.pop_front());
            end
          endcase
        end
        smp_if.valid <= give_smp;
        if (give_smp) begin
          smp_if.accel_x <= job.ax;
          smp_if.accel_y <= job.ay;
          smp_if.accel_z <= job.az;
        end
        cfg_if.valid <= give_cfg;
        if (give_cfg) begin
          cfg_if.index <= job.idx;
          cfg_if.data  <= job.data;
        end
      end
    end
  end

  // monitor: predict on accepted samples, check accepted result words
  always @(posedge clk_i) begin : track
    step_word_t want;
    if (rst_ni) begin
      if (cfg_if.valid && cfg_if.ready) begin
        apply_cfg(cfg_if.index, cfg_if.data);
        cfg_count++;
      end
      if (smp_if.valid && smp_if.ready) begin
        step_words_due.push_back(next_step_word(smp_if.accel_x, smp_if.accel_y,
                                                smp_if.accel_z));
        smp_count++;
      end
      if (res_if.valid && res_if.ready) begin
        word_count++;
        if (res_if.step_detected) step_count++;
        if (step_words_due.size() == 0) begin
          flag_mismatch("result word with nothing expected");
        end else begin
          want = step_words_due.pop_front();
          if (res_if.step_detected !== want.step)
            flag_mismatch($sformatf("word %0d step_detected %b, expected %b", word_count,
                                    res_if.step_detected, want.step));
          if (res_if.smoothed_magnitude !== want.smooth)
            flag_mismatch($sformatf("word %0d smoothed_magnitude %0d, expected %0d",
                                    word_count, res_if.smoothed_magnitude, want.smooth));
        end
      end
    end
    smp_fire <= rst_ni && smp_if.valid && smp_if.ready;
    cfg_fire <= rst_ni && cfg_if.valid && cfg_if.ready;
  end

  // watchdog on cycles with no word moving on any channel
  always @(posedge clk_i) begin : watchdog
    if ((smp_if.valid && smp_if.ready) || (res_if.valid && res_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout after %0d quiet cycles", quiet_cycles);
      $display("Regression FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
